// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define MRBM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define MRBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/mrbm_pkg.sv -----
// ---------------------------------------------------------------------------
// mrbm_pkg
// Types and constants of the modem reply byte matcher.
// ---------------------------------------------------------------------------
package mrbm_pkg;

    localparam logic [7:0] BODY_SIZE    = 8'd64;
    localparam logic [7:0] INDEX_DIGITS = 8'd10;
    localparam logic [7:0] CMD_PREFIX   = 8'd8;
    localparam logic [7:0] OK_PAIR_SUM  = 8'd154;
    localparam logic [15:0] NOTICE_SUM  = 16'd649;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_NL        = 8'h0A;

    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_FETCH    = 2'd1;
    localparam logic [1:0] CMD_ACK_OK   = 2'd2;
    localparam logic [1:0] CMD_SEND_RST = 2'd3;

    localparam logic [1:0] STORE_NONE  = 2'd0;
    localparam logic [1:0] STORE_DIGIT = 2'd1;
    localparam logic [1:0] STORE_BODY  = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } req_item_t;

    typedef struct packed {
        logic       ok_out;
        logic       notice_out;
        logic [1:0] store_kind;
        logic [7:0] store_pos;
        logic [7:0] store_byte;
        logic       overflow;
        logic       issue_read;
        logic [4:0] read_cmd_len;
    } rsp_item_t;

endpackage

// ----- hw/rtl/mrbm_ifs.sv -----
// ---------------------------------------------------------------------------
// mrbm channel interfaces
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface mrbm_req_if;
    logic                 valid;
    logic                 ready;
    mrbm_pkg::req_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mrbm_rsp_if;
    logic                 valid;
    logic                 ready;
    mrbm_pkg::rsp_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/modem_reply_byte_matcher.sv -----
// ---------------------------------------------------------------------------
// modem_reply_byte_matcher
// Tracks OK replies and new-message notices in a modem byte stream and
// emits index-digit and body-byte stores, one result beat per command beat.
// ---------------------------------------------------------------------------
//   channel | dir | payload
//   req     | in  | command, rx_byte
//   rsp     | out | ok_out, notice_out, store_kind/pos/byte, overflow,
//           |     | issue_read, read_cmd_len
//
// One beat per cycle sustained while rsp does not stall; results are registered.
// State and result come from one combinational pass over the tracker registers.
// A two-entry result buffer (output plus skid register) keeps req.ready high
// while the skid register is empty; req stalls only when both are full.
// Reset clears all tracker state and empties the result buffer.
module modem_reply_byte_matcher (
    input  logic              clk,
    input  logic              rst_n,
    mrbm_req_if.sink          req,
    mrbm_rsp_if.source        rsp
);
    import mrbm_pkg::*;

    logic        ok_seen_reg,        ok_seen_next;
    logic [7:0]  prev_byte_reg,      prev_byte_next;
    logic [7:0]  last_byte_reg,      last_byte_next;
    logic        notice_armed_reg,   notice_armed_next;
    logic        reading_body_reg,   reading_body_next;
    logic        notice_pending_reg, notice_pending_next;
    logic [15:0] header_sum_reg,     header_sum_next;
    logic [7:0]  write_index_reg,    write_index_next;

    logic        out_valid_reg,  skid_valid_reg;
    rsp_item_t   out_data_reg,   skid_data_reg;
    rsp_item_t   result;
    logic        req_fire, out_free;

    assign req.ready = !skid_valid_reg;
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        logic [7:0] b;
        logic [7:0] n;
        logic [7:0] pb;
        logic [7:0] lb;
        b  = req.data.rx_byte;
        n  = 8'd0;
        pb = prev_byte_reg;
        lb = last_byte_reg;

        ok_seen_next        = ok_seen_reg;
        prev_byte_next      = prev_byte_reg;
        last_byte_next      = last_byte_reg;
        notice_armed_next   = notice_armed_reg;
        reading_body_next   = reading_body_reg;
        notice_pending_next = notice_pending_reg;
        header_sum_next     = header_sum_reg;
        write_index_next    = write_index_reg;
        result              = '0;

        unique case (req.data.command)
            CMD_BYTE:
            begin
                if (!ok_seen_reg)
                begin
                    pb = last_byte_reg;
                    lb = b;
                    if (8'(pb + lb) == OK_PAIR_SUM)
                    begin
                        ok_seen_next   = 1'b1;
                        prev_byte_next = 8'd0;
                        last_byte_next = 8'd0;
                    end
                    else
                    begin
                        prev_byte_next = pb;
                        last_byte_next = lb;
                    end
                end

                if (b == CH_PLUS)
                begin
                    header_sum_next = 16'd0;
                    if (notice_armed_reg)
                    begin
                        notice_armed_next = 1'b0;
                        reading_body_next = 1'b1;
                    end
                    else
                    begin
                        notice_armed_next = 1'b1;
                    end
                end
                else if (notice_armed_reg)
                begin
                    if (header_sum_reg == NOTICE_SUM)
                    begin
                        if (write_index_reg < INDEX_DIGITS)
                        begin
                            result.store_kind = STORE_DIGIT;
                            result.store_pos  = 8'(CMD_PREFIX + write_index_reg);
                            result.store_byte = b;
                            write_index_next  = 8'(write_index_reg + 8'd1);
                        end
                        else
                        begin
                            result.overflow = 1'b1;
                        end
                        if (b == CH_NL)
                        begin
                            notice_pending_next = 1'b1;
                            header_sum_next     = 16'd0;
                        end
                    end
                    else
                    begin
                        header_sum_next = 16'(header_sum_reg + {8'd0, b});
                    end
                end
                else if (reading_body_reg)
                begin
                    // ok_seen here is the value after the pair check above
                    if (!ok_seen_next)
                    begin
                        if (write_index_reg < BODY_SIZE)
                        begin
                            result.store_kind = STORE_BODY;
                            result.store_pos  = write_index_reg;
                            result.store_byte = b;
                            write_index_next  = 8'(write_index_reg + 8'd1);
                        end
                        else
                        begin
                            result.overflow = 1'b1;
                        end
                    end
                    else
                    begin
                        reading_body_next = 1'b0;
                        ok_seen_next      = 1'b0;
                        write_index_next  = 8'd0;
                    end
                end
            end
            CMD_FETCH:
            begin
                if (notice_pending_reg)
                begin
                    n = (write_index_reg > INDEX_DIGITS) ? INDEX_DIGITS : write_index_reg;
                    result.issue_read   = 1'b1;
                    result.read_cmd_len = 5'(CMD_PREFIX + n);
                    write_index_next    = 8'd0;
                    notice_pending_next = 1'b0;
                end
            end
            CMD_ACK_OK:
            begin
                ok_seen_next = 1'b0;
            end
            CMD_SEND_RST:
            begin
                write_index_next    = 8'd0;
                notice_pending_next = 1'b0;
                notice_armed_next   = 1'b0;
                reading_body_next   = 1'b0;
                ok_seen_next        = 1'b0;
                header_sum_next     = 16'd0;
            end
        endcase

        result.ok_out     = ok_seen_next;
        result.notice_out = notice_pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_seen_reg        <= 1'b0;
            prev_byte_reg      <= 8'd0;
            last_byte_reg      <= 8'd0;
            notice_armed_reg   <= 1'b0;
            reading_body_reg   <= 1'b0;
            notice_pending_reg <= 1'b0;
            header_sum_reg     <= 16'd0;
            write_index_reg    <= 8'd0;
        end
        else if (req_fire)
        begin
            ok_seen_reg        <= ok_seen_next;
            prev_byte_reg      <= prev_byte_next;
            last_byte_reg      <= last_byte_next;
            notice_armed_reg   <= notice_armed_next;
            reading_body_reg   <= reading_body_next;
            notice_pending_reg <= notice_pending_next;
            header_sum_reg     <= header_sum_next;
            write_index_reg    <= write_index_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= req_fire;
            end
            else
            begin
                out_valid_reg <= req_fire;
            end
        end
        else if (req_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (req_fire)
                begin
                    skid_data_reg <= result;
                end
            end
            else if (req_fire)
            begin
                out_data_reg <= result;
            end
        end
        else if (req_fire)
        begin
            skid_data_reg <= result;
        end
    end

`include "assert_macros.svh"

    `MRBM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `MRBM_ASSERT(a_index_bounded, write_index_reg <= BODY_SIZE || write_index_reg <= INDEX_DIGITS)
    `MRBM_ASSERT_IMP(a_read_len, out_valid_reg && out_data_reg.issue_read, out_data_reg.read_cmd_len >= 5'(CMD_PREFIX))

endmodule

// ----- sim/modem_reply_byte_matcher_tb.sv -----
// ---------------------------------------------------------------------------
// modem_reply_byte_matcher_tb
// Self-checking bench for the modem reply byte matcher. A short table of
// command beats covers OK pairs, notice headers, index digits, body stores
// and every command. Random reply sequences follow: notices, bodies, OK
// replies and noise. Each result beat is checked field by field against a
// table row or a behavioral tracker, under varying source and sink stalls.
// ---------------------------------------------------------------------------
module modem_reply_byte_matcher_tb;
    import mrbm_pkg::*;

    localparam int BEAT_GOAL    = 1350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int PLAN_ROWS    = 22;

    localparam rsp_item_t NO_REPLY = '0;
    localparam rsp_item_t OK_REPLY = '{1'b1, 1'b0, STORE_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 5'd0};

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx;
        logic       typed;
        rsp_item_t  want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    mrbm_req_if req_ch ();
    mrbm_rsp_if rsp_ch ();

    modem_reply_byte_matcher dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // tracker state
    logic        trk_ok;
    logic [7:0]  trk_prev;
    logic [7:0]  trk_last;
    logic        trk_armed;
    logic        trk_body;
    logic        trk_pending;
    logic [15:0] trk_hsum;
    logic [7:0]  trk_widx;

    rsp_item_t replies_due[$];
    plan_row_t plan [PLAN_ROWS];
    string     notice_text = "CMTI: \"ME\",";

    int    send_idle_pct;
    int    recv_idle_pct;
    bit    hold_rsp;
    int    errors;
    int    beats_sent;
    int    results_seen;
    int    digit_stores;
    int    body_stores;
    int    suppressed;
    int    reads_issued;
    int    cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 replies_due.size());
        $display("modem_reply_byte_matcher: mismatch");
        $finish;
    end

    function automatic rsp_item_t advance_tracker(input req_item_t beat);
        rsp_item_t  r;
        logic [7:0] b;
        logic [7:0] pair_sum;
        logic [7:0] digits;
        r = '0;
        b = beat.rx_byte;
        case (beat.command)
            CMD_BYTE:
            begin
                if (!trk_ok)
                begin
                    trk_prev = trk_last;
                    trk_last = b;
                    pair_sum = trk_prev + trk_last;
                    if (pair_sum == OK_PAIR_SUM)
                    begin
                        trk_ok   = 1'b1;
                        trk_prev = '0;
                        trk_last = '0;
                    end
                end
                if (b == CH_PLUS)
                begin
                    trk_hsum = '0;
                    if (trk_armed)
                    begin
                        trk_armed = 1'b0;
                        trk_body  = 1'b1;
                    end
                    else
                        trk_armed = 1'b1;
                end
                else if (trk_armed)
                begin
                    if (trk_hsum == NOTICE_SUM)
                    begin
                        if (trk_widx < INDEX_DIGITS)
                        begin
                            r.store_kind = STORE_DIGIT;
                            r.store_pos  = CMD_PREFIX + trk_widx;
                            r.store_byte = b;
                            trk_widx     = trk_widx + 8'd1;
                        end
                        else
                            r.overflow = 1'b1;
                        if (b == CH_NL)
                        begin
                            trk_pending = 1'b1;
                            trk_hsum    = '0;
                        end
                    end
                    else
                        trk_hsum = trk_hsum + {8'd0, b};
                end
                else if (trk_body)
                begin
                    if (!trk_ok)
                    begin
                        if (trk_widx < BODY_SIZE)
                        begin
                            r.store_kind = STORE_BODY;
                            r.store_pos  = trk_widx;
                            r.store_byte = b;
                            trk_widx     = trk_widx + 8'd1;
                        end
                        else
                            r.overflow = 1'b1;
                    end
                    else
                    begin
                        trk_body = 1'b0;
                        trk_ok   = 1'b0;
                        trk_widx = '0;
                    end
                end
            end
            CMD_FETCH:
            begin
                if (trk_pending)
                begin
                    digits         = (trk_widx > INDEX_DIGITS) ? INDEX_DIGITS : trk_widx;
                    r.issue_read   = 1'b1;
                    r.read_cmd_len = 5'(CMD_PREFIX + digits);
                    trk_widx       = '0;
                    trk_pending    = 1'b0;
                end
            end
            CMD_ACK_OK:
                trk_ok = 1'b0;
            default:
            begin
                trk_widx    = '0;
                trk_pending = 1'b0;
                trk_armed   = 1'b0;
                trk_body    = 1'b0;
                trk_ok      = 1'b0;
                trk_hsum    = '0;
            end
        endcase
        r.ok_out     = trk_ok;
        r.notice_out = trk_pending;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_reply(input rsp_item_t got);
        rsp_item_t want;
        if (replies_due.size() == 0)
        begin
            $display("%0t: result beat expected none got %p", $time, got);
            errors++;
        end
        else
        begin
            want = replies_due.pop_front();
            results_seen++;
            compare_field("ok_out", 8'(want.ok_out), 8'(got.ok_out));
            compare_field("notice_out", 8'(want.notice_out), 8'(got.notice_out));
            compare_field("store_kind", 8'(want.store_kind), 8'(got.store_kind));
            compare_field("store_pos", want.store_pos, got.store_pos);
            compare_field("store_byte", want.store_byte, got.store_byte);
            compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
            compare_field("issue_read", 8'(want.issue_read), 8'(got.issue_read));
            compare_field("read_cmd_len", 8'(want.read_cmd_len), 8'(got.read_cmd_len));
            if (want.store_kind == STORE_DIGIT)
                digit_stores++;
            if (want.store_kind == STORE_BODY)
                body_stores++;
            if (want.overflow)
                suppressed++;
            if (want.issue_read)
                reads_issued++;
        end
    endtask

    // result sink
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                check_reply(rsp_ch.data);
            if (hold_rsp)
            begin
                hold_rsp  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic offer_beat(input logic [1:0] cmd, input logic [7:0] rx,
                              input logic typed, input rsp_item_t typed_rsp);
        req_item_t beat;
        rsp_item_t guess;
        beat.command = cmd;
        beat.rx_byte = rx;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= beat;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        guess = advance_tracker(beat);
        replies_due.push_back(typed ? typed_rsp : guess);
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer_beat(CMD_BYTE, b, 1'b0, NO_REPLY);
    endtask

    task automatic send_cmd(input logic [1:0] cmd);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        offer_beat(cmd, junk, 1'b0, NO_REPLY);
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
    endtask

    task automatic send_random_sequence();
        int         kind;
        int         n;
        int         i;
        logic [7:0] b;
        logic [1:0] cmd;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // new-message notice, sometimes with a corrupted header
            send_byte(CH_PLUS);
            for (i = 0; i < notice_text.len(); i++)
            begin
                b = notice_text[i];
                if ($urandom_range(0, 99) < 8)
                    b = 8'($urandom_range(0, 255));
                send_byte(b);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                b = 8'(8'h30 + $urandom_range(0, 9));
                send_byte(b);
            end
            send_byte(CH_NL);
            if ($urandom_range(0, 99) < 80)
                send_cmd(CMD_FETCH);
        end
        else if (kind < 55)
        begin
            // read reply body, usually closed by OK
            send_byte(CH_PLUS);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 20);
            for (i = 0; i < n; i++)
            begin
                b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                                : 8'($urandom_range(0, 255));
                send_byte(b);
            end
            if ($urandom_range(0, 99) < 70)
            begin
                send_byte("O");
                send_byte("K");
                send_byte(8'h0D);
            end
        end
        else if (kind < 65)
        begin
            send_byte(8'h0D);
            send_byte(CH_NL);
            send_byte("O");
            send_byte("K");
            send_byte(8'h0D);
            send_byte(CH_NL);
            if ($urandom_range(0, 99) < 70)
                send_cmd(CMD_ACK_OK);
        end
        else if (kind < 75)
        begin
            cmd = 2'($urandom_range(1, 3));
            send_cmd(cmd);
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
            begin
                cmd = 2'($urandom_range(0, 3));
                b   = 8'($urandom_range(0, 255));
                offer_beat(cmd, b, 1'b0, NO_REPLY);
            end
        end
    endtask

    initial
    begin
        int i;
        int phase;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        send_idle_pct = 37;
        recv_idle_pct = 61;
        hold_rsp      = 1'b0;
        errors        = 0;
        beats_sent    = 0;
        results_seen  = 0;
        digit_stores  = 0;
        body_stores   = 0;
        suppressed    = 0;
        reads_issued  = 0;
        trk_ok        = 1'b0;
        trk_prev      = '0;
        trk_last      = '0;
        trk_armed     = 1'b0;
        trk_body      = 1'b0;
        trk_pending   = 1'b0;
        trk_hsum      = '0;
        trk_widx      = '0;

        plan[0]  = '{CMD_FETCH,    8'hFF, 1'b1, NO_REPLY};  // nothing pending
        plan[1]  = '{CMD_BYTE,     8'h4F, 1'b0, NO_REPLY};
        plan[2]  = '{CMD_BYTE,     8'h4B, 1'b1, OK_REPLY};
        plan[3]  = '{CMD_ACK_OK,   8'h00, 1'b1, NO_REPLY};
        plan[4]  = '{CMD_BYTE,     8'hFF, 1'b0, NO_REPLY};
        plan[5]  = '{CMD_BYTE,     8'h9B, 1'b0, NO_REPLY};  // pair sum wraps to OK
        plan[6]  = '{CMD_SEND_RST, 8'hFF, 1'b1, NO_REPLY};
        plan[7]  = '{CMD_BYTE,     CH_PLUS, 1'b0, NO_REPLY};
        plan[8]  = '{CMD_BYTE,     8'hFF, 1'b0, NO_REPLY};
        plan[9]  = '{CMD_BYTE,     8'hFF, 1'b0, NO_REPLY};
        plan[10] = '{CMD_BYTE,     8'h8B, 1'b0, NO_REPLY};  // header sum hits 649
        plan[11] = '{CMD_BYTE,     8'h37, 1'b0, NO_REPLY};
        plan[12] = '{CMD_BYTE,     CH_NL, 1'b0, NO_REPLY};
        plan[13] = '{CMD_FETCH,    8'h00, 1'b0, NO_REPLY};
        plan[14] = '{CMD_BYTE,     CH_PLUS, 1'b0, NO_REPLY};
        plan[15] = '{CMD_BYTE,     8'h00, 1'b0, NO_REPLY};
        plan[16] = '{CMD_BYTE,     8'hFF, 1'b0, NO_REPLY};
        plan[17] = '{CMD_BYTE,     8'h4F, 1'b0, NO_REPLY};
        plan[18] = '{CMD_BYTE,     8'h4B, 1'b0, NO_REPLY};
        plan[19] = '{CMD_BYTE,     CH_PLUS, 1'b0, NO_REPLY};
        plan[20] = '{CMD_SEND_RST, 8'h00, 1'b1, NO_REPLY};
        plan[21] = '{CMD_ACK_OK,   8'hFF, 1'b1, NO_REPLY};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_ROWS; i++)
            offer_beat(plan[i].cmd, plan[i].rx, plan[i].typed, plan[i].want);

        for (phase = 0; phase < 3; phase++)
        begin
            drain_replies();
            case (phase)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 61;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 1)
            begin
                // header sum wraps past 2^16 before landing on 649
                send_cmd(CMD_SEND_RST);
                send_byte(CH_PLUS);
                repeat (258) send_byte(8'hFF);
                send_byte(8'hFF);
                send_byte(8'h8C);
                send_byte(8'h33);
                send_byte(CH_NL);
                send_cmd(CMD_FETCH);
            end
            if (phase == 2)
                hold_rsp = 1'b1;
            while (beats_sent < BEAT_GOAL * (phase + 1) / 3)
                send_random_sequence();
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d command beats, %0d result beats checked in %0d cycles", beats_sent,
                 results_seen, cycles);
        $display("index digits %0d, body bytes %0d, suppressed stores %0d, reads %0d",
                 digit_stores, body_stores, suppressed, reads_issued);
        if (errors == 0)
            $display("modem_reply_byte_matcher: match");
        else
            $display("modem_reply_byte_matcher: mismatch");
        $finish;
    end

endmodule
